[design/assert_macros.svh]
// Assertion macros for the ternary 3x3 convolution RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define TCV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define TCV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TCV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/tcv_pkg.sv]
// Shared constants and types for the ternary 3x3 convolution.
// No dependencies.
package tcv_pkg;

  localparam int PIXEL_W   = 16;
  localparam int FEAT_W    = 20;
  localparam int MAX_WIDTH = 64;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 10;
  localparam int PLANE_W   = 2;
  localparam int KIDX_W    = 3;
  localparam int KERNELS   = 8;
  localparam int TAPS      = 9;
  localparam int KERN_W    = 2 * TAPS;
  localparam int KREGS     = 4;
  localparam int CFG_W     = 2 * KERN_W;
  localparam int CFG_IDX_W = 3;
  localparam int WIDTH_W   = 7;
  localparam int HEIGHT_W  = 11;
  localparam int CHAN_W    = 3;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_CHANS  = 4;
  localparam int MIN_DIM    = 3;
  localparam int LINE_W    = 2 * PIXEL_W;

  typedef logic signed [PIXEL_W-1:0] pixel_t;
  typedef logic signed [FEAT_W-1:0]  feat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K01    = 3'd0,
    CFG_K23    = 3'd1,
    CFG_K45    = 3'd2,
    CFG_K67    = 3'd3,
    CFG_WIDTH  = 3'd4,
    CFG_HEIGHT = 3'd5,
    CFG_CHANS  = 3'd6
  } cfg_idx_t;

endpackage

[design/tcv_ifs.sv]
// Valid/ready channel interfaces for pixel requests and feature results.
// Depends on tcv_pkg.
interface tcv_pix_if;
  logic            valid;
  logic            ready;
  tcv_pkg::pixel_t pixel;
  logic            image_start;

  modport source (output valid, pixel, image_start, input ready);
  modport sink   (input valid, pixel, image_start, output ready);
endinterface

interface tcv_res_if;
  logic                          valid;
  logic                          ready;
  tcv_pkg::feat_t                feature;
  logic [tcv_pkg::KIDX_W-1:0]    kernel_index;
  logic [tcv_pkg::PLANE_W-1:0]   plane;
  logic [tcv_pkg::COL_W-1:0]     out_col;
  logic [tcv_pkg::ROW_W-1:0]     out_row;
  logic                          last_of_run;
  logic                          end_of_image;

  modport source (output valid, feature, kernel_index, plane, out_col, out_row,
                  last_of_run, end_of_image, input ready);
  modport sink   (input valid, feature, kernel_index, plane, out_col, out_row,
                  last_of_run, end_of_image, output ready);
endinterface

[design/ternary_3x3_convolution.sv]
// Top level of the ternary-weight 3x3 valid-mode convolution.
// Depends on tcv_pkg, tcv_ifs (tcv_pix_if, tcv_res_if), tcv_ram, assert_macros.svh.
//
//   channel  | dir | payload
//   in_px    | in  | pixel, image_start
//   out_res  | out | feature, kernel_index, plane, out_col, out_row,
//            |     | last_of_run, end_of_image
//   cfg_*    | in  | cfg_we, cfg_index, cfg_data (write only)
//
// A pixel that completes a window runs the eight kernels in turn through the
// single nine-input adder tree, one result per kernel. A result passes the
// read stage, the window registers and the output register. Both line rows
// sit in one 64x32 RAM indexed by column; no clearing pass follows reset.
// Reset is synchronous and active low.
// A stalled output holds its result while the next pixel is read from the RAM.
`include "assert_macros.svh"

module ternary_3x3_convolution (
  input  logic                           clk,
  input  logic                           rst_n,
  tcv_pix_if.sink                        in_px,
  tcv_res_if.source                      out_res,
  input  logic                           cfg_we,
  input  logic [tcv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcv_pkg::CFG_W-1:0]      cfg_data
);

  typedef enum logic [1:0] {
    W_ZERO  = 2'd0,
    W_PLUS  = 2'd1,
    W_MINUS = 2'd3
  } tap_code_t;

  function automatic tcv_pkg::feat_t kernel_sum(
    logic [tcv_pkg::KERN_W-1:0]              taps,
    logic [tcv_pkg::TAPS*tcv_pkg::PIXEL_W-1:0] win
  );
    tcv_pkg::feat_t acc;
    tcv_pkg::feat_t term;
    acc = '0;
    for (int t = 0; t < tcv_pkg::TAPS; t++) begin
      term = tcv_pkg::feat_t'(tcv_pkg::pixel_t'(win[t*tcv_pkg::PIXEL_W +: tcv_pkg::PIXEL_W]));
      case (tap_code_t'(taps[2*t +: 2]))
        W_PLUS:  acc = acc + term;
        W_MINUS: acc = acc - term;
        default: acc = acc;
      endcase
    end
    return acc;
  endfunction

  // configuration
  logic [tcv_pkg::CFG_W-1:0]    kern_r [tcv_pkg::KREGS];
  logic [tcv_pkg::WIDTH_W-1:0]  width_r;
  logic [tcv_pkg::HEIGHT_W-1:0] height_r;
  logic [tcv_pkg::CHAN_W-1:0]   chans_r;
  logic [tcv_pkg::WIDTH_W-1:0]  width_cfg;
  logic [tcv_pkg::HEIGHT_W-1:0] height_cfg;
  logic [tcv_pkg::CHAN_W-1:0]   chans_cfg;

  // position counters
  logic [tcv_pkg::COL_W-1:0]   col_r, col_nxt, col_cur;
  logic [tcv_pkg::ROW_W-1:0]   row_r, row_nxt, row_cur;
  logic [tcv_pkg::PLANE_W-1:0] plane_r, plane_nxt, plane_cur;
  logic [tcv_pkg::WIDTH_W-1:0]  col_inc;
  logic [tcv_pkg::HEIGHT_W-1:0] row_inc;
  logic [tcv_pkg::CHAN_W-1:0]   plane_inc;
  logic in_fire, emit, last_win;

  // read stage
  logic                        b_valid_r;
  tcv_pkg::pixel_t             b_px_r;
  logic [tcv_pkg::COL_W-1:0]   b_col_r;
  logic                        b_emit_r;
  logic                        b_last_r;
  logic [tcv_pkg::PLANE_W-1:0] b_plane_r;
  logic [tcv_pkg::COL_W-1:0]   b_ocol_r;
  logic [tcv_pkg::ROW_W-1:0]   b_orow_r;
  logic                        fwd_r;
  logic [tcv_pkg::LINE_W-1:0]  fwd_data_r;
  logic [tcv_pkg::LINE_W-1:0]  ram_rdata_r, line_rd, line_wr;
  logic                        b_fire;

  // window and kernel run
  tcv_pkg::pixel_t                           win_r [tcv_pkg::TAPS];
  logic [tcv_pkg::TAPS*tcv_pkg::PIXEL_W-1:0] win_flat;
  logic                        run_r;
  logic [tcv_pkg::KIDX_W-1:0]  kcnt_r;
  logic [tcv_pkg::PLANE_W-1:0] run_plane_r;
  logic [tcv_pkg::COL_W-1:0]   run_col_r;
  logic [tcv_pkg::ROW_W-1:0]   run_row_r;
  logic                        run_last_r;
  logic                        load, run_done, kern_last;
  logic [tcv_pkg::CFG_W-1:0]   kpair;
  logic [tcv_pkg::KERN_W-1:0]  ksel;

  // output register
  logic                        out_valid_r;
  tcv_pkg::feat_t              feature_r;
  logic [tcv_pkg::KIDX_W-1:0]  kidx_r;
  logic [tcv_pkg::PLANE_W-1:0] oplane_r;
  logic [tcv_pkg::COL_W-1:0]   ocol_r;
  logic [tcv_pkg::ROW_W-1:0]   orow_r;
  logic                        olast_r;
  logic                        oend_r;
  logic                        out_fire;

  // ---------------- configuration ----------------
  always_comb begin
    width_cfg = cfg_data[tcv_pkg::WIDTH_W-1:0];
    if (width_cfg < tcv_pkg::WIDTH_W'(tcv_pkg::MIN_DIM)) begin
      width_cfg = tcv_pkg::WIDTH_W'(tcv_pkg::MIN_DIM);
    end else if (width_cfg > tcv_pkg::WIDTH_W'(tcv_pkg::MAX_WIDTH)) begin
      width_cfg = tcv_pkg::WIDTH_W'(tcv_pkg::MAX_WIDTH);
    end
    height_cfg = cfg_data[tcv_pkg::HEIGHT_W-1:0];
    if (height_cfg < tcv_pkg::HEIGHT_W'(tcv_pkg::MIN_DIM)) begin
      height_cfg = tcv_pkg::HEIGHT_W'(tcv_pkg::MIN_DIM);
    end else if (height_cfg > tcv_pkg::HEIGHT_W'(tcv_pkg::MAX_HEIGHT)) begin
      height_cfg = tcv_pkg::HEIGHT_W'(tcv_pkg::MAX_HEIGHT);
    end
    chans_cfg = cfg_data[tcv_pkg::CHAN_W-1:0];
    if (chans_cfg < tcv_pkg::CHAN_W'(1)) begin
      chans_cfg = tcv_pkg::CHAN_W'(1);
    end else if (chans_cfg > tcv_pkg::CHAN_W'(tcv_pkg::MAX_CHANS)) begin
      chans_cfg = tcv_pkg::CHAN_W'(tcv_pkg::MAX_CHANS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tcv_pkg::KREGS; i++) begin
        kern_r[i] <= '0;
      end
      width_r  <= tcv_pkg::WIDTH_W'(28);
      height_r <= tcv_pkg::HEIGHT_W'(28);
      chans_r  <= tcv_pkg::CHAN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        tcv_pkg::CFG_K01:    kern_r[0] <= cfg_data;
        tcv_pkg::CFG_K23:    kern_r[1] <= cfg_data;
        tcv_pkg::CFG_K45:    kern_r[2] <= cfg_data;
        tcv_pkg::CFG_K67:    kern_r[3] <= cfg_data;
        tcv_pkg::CFG_WIDTH:  width_r   <= width_cfg;
        tcv_pkg::CFG_HEIGHT: height_r  <= height_cfg;
        tcv_pkg::CFG_CHANS:  chans_r   <= chans_cfg;
        default: ;
      endcase
    end
  end

  // ---------------- request stage ----------------
  assign in_fire     = in_px.valid && in_px.ready;
  assign in_px.ready = !b_valid_r || b_fire;

  always_comb begin
    col_cur   = in_px.image_start ? '0 : col_r;
    row_cur   = in_px.image_start ? '0 : row_r;
    plane_cur = in_px.image_start ? '0 : plane_r;
    col_inc   = {1'b0, col_cur} + tcv_pkg::WIDTH_W'(1);
    row_inc   = {1'b0, row_cur} + tcv_pkg::HEIGHT_W'(1);
    plane_inc = {1'b0, plane_cur} + tcv_pkg::CHAN_W'(1);
    emit      = (col_cur >= tcv_pkg::COL_W'(2)) && (row_cur >= tcv_pkg::ROW_W'(2));
    last_win  = ({1'b0, col_cur} >= width_r - tcv_pkg::WIDTH_W'(1)) &&
                ({1'b0, row_cur} >= height_r - tcv_pkg::HEIGHT_W'(1)) &&
                ({1'b0, plane_cur} >= chans_r - tcv_pkg::CHAN_W'(1));
    col_nxt   = col_inc[tcv_pkg::COL_W-1:0];
    row_nxt   = row_cur;
    plane_nxt = plane_cur;
    if (col_inc >= width_r) begin
      col_nxt = '0;
      if (row_inc >= height_r) begin
        row_nxt   = '0;
        plane_nxt = (plane_inc >= chans_r) ? '0 : plane_inc[tcv_pkg::PLANE_W-1:0];
      end else begin
        row_nxt = row_inc[tcv_pkg::ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      plane_r   <= '0;
      b_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        plane_r <= plane_nxt;
        fwd_r   <= b_fire && (col_cur == b_col_r);
      end
      if (in_fire) begin
        b_valid_r <= 1'b1;
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_px_r     <= in_px.pixel;
      b_col_r    <= col_cur;
      b_emit_r   <= emit;
      b_last_r   <= last_win;
      b_plane_r  <= plane_cur;
      b_ocol_r   <= col_cur - tcv_pkg::COL_W'(2);
      b_orow_r   <= row_cur - tcv_pkg::ROW_W'(2);
      fwd_data_r <= line_wr;
    end
  end

  // ---------------- line store ----------------
  // word layout: upper half is the older row, lower half the newer row
  assign line_rd = fwd_r ? fwd_data_r : ram_rdata_r;
  assign line_wr = {line_rd[tcv_pkg::PIXEL_W-1:0], b_px_r};

  tcv_ram #(
    .WIDTH (tcv_pkg::LINE_W),
    .DEPTH (tcv_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .we      (b_fire),
    .waddr   (b_col_r),
    .wdata   (line_wr),
    .re      (in_fire),
    .raddr   (col_cur),
    .rdata_r (ram_rdata_r)
  );

  // ---------------- window and kernel run ----------------
  assign kern_last = (kcnt_r == tcv_pkg::KIDX_W'(tcv_pkg::KERNELS - 1));
  assign load      = run_r && (!out_valid_r || out_res.ready);
  assign run_done  = load && kern_last;
  assign b_fire    = b_valid_r && (!run_r || run_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tcv_pkg::TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (b_fire) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= tcv_pkg::pixel_t'(line_rd[tcv_pkg::LINE_W-1:tcv_pkg::PIXEL_W]);
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= tcv_pkg::pixel_t'(line_rd[tcv_pkg::PIXEL_W-1:0]);
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= b_px_r;
    end
  end

  always_comb begin
    for (int i = 0; i < tcv_pkg::TAPS; i++) begin
      win_flat[i*tcv_pkg::PIXEL_W +: tcv_pkg::PIXEL_W] = win_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      kcnt_r <= '0;
    end else begin
      if (b_fire && b_emit_r) begin
        run_r  <= 1'b1;
        kcnt_r <= '0;
      end else if (run_done) begin
        run_r  <= 1'b0;
        kcnt_r <= '0;
      end else if (load) begin
        kcnt_r <= kcnt_r + tcv_pkg::KIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_emit_r) begin
      run_plane_r <= b_plane_r;
      run_col_r   <= b_ocol_r;
      run_row_r   <= b_orow_r;
      run_last_r  <= b_last_r;
    end
  end

  assign kpair = kern_r[kcnt_r[tcv_pkg::KIDX_W-1:1]];
  assign ksel  = kcnt_r[0] ? kpair[tcv_pkg::CFG_W-1:tcv_pkg::KERN_W]
                           : kpair[tcv_pkg::KERN_W-1:0];

  // ---------------- output register ----------------
  assign out_fire = out_valid_r && out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      feature_r <= kernel_sum(ksel, win_flat);
      kidx_r    <= kcnt_r;
      oplane_r  <= run_plane_r;
      ocol_r    <= run_col_r;
      orow_r    <= run_row_r;
      olast_r   <= kern_last;
      oend_r    <= kern_last && run_last_r;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.feature      = feature_r;
  assign out_res.kernel_index = kidx_r;
  assign out_res.plane        = oplane_r;
  assign out_res.out_col      = ocol_r;
  assign out_res.out_row      = orow_r;
  assign out_res.last_of_run  = olast_r;
  assign out_res.end_of_image = oend_r;

  // ---------------- checks ----------------
  `TCV_ASSERT_NXT(a_win_hold, clk, rst_n, run_r && !run_done, $stable(win_flat))
  `TCV_ASSERT_IMP(a_kcnt_idle, clk, rst_n, !run_r, kcnt_r == '0)
  `TCV_ASSERT_NXT(a_run_cont, clk, rst_n, out_fire && !olast_r, out_valid_r)

endmodule

[design/tcv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

[sim/tcv_tb_pkg.sv]
// Testbench-side codes for the ternary 3x3 convolution: tap weight encoding
// and a register index beyond the defined list. Depends on tcv_pkg.
package tcv_tb_pkg;

  typedef enum logic [1:0] {
    W_ZERO  = 2'b00,
    W_PLUS  = 2'b01,
    W_SPARE = 2'b10,
    W_MINUS = 2'b11
  } weight_code_t;

  localparam logic [tcv_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

endpackage

[sim/tcv_feature_checker.sv]
// Feature checker: mirrors the line stores, window and kernel registers,
// predicts every feature result and compares it with the result channel.
// Depends on tcv_pkg, tcv_tb_pkg and the channel interfaces in tcv_ifs.
module tcv_feature_checker
  import tcv_pkg::*;
  import tcv_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  tcv_pix_if                   px_ch,
  tcv_res_if                   res_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen,
  output int                   images_done
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    feat_t               feature;
    logic [KIDX_W-1:0]   kidx;
    logic [PLANE_W-1:0]  plane;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic                last;
    logic                eoi;
  } feat_rec_t;

  logic [CFG_W-1:0]    kern_bank [KREGS];
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [CHAN_W-1:0]   chan_reg;
  pixel_t              rows_mem [2][MAX_WIDTH];
  pixel_t              win [TAPS];
  int unsigned         col_c, row_c, plane_c;
  feat_rec_t           feature_q [$];

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_model();
    foreach (kern_bank[i]) kern_bank[i] = '0;
    width_reg  = 28;
    height_reg = 28;
    chan_reg   = 1;
    foreach (rows_mem[r, c]) rows_mem[r][c] = '0;
    foreach (win[t]) win[t] = '0;
    col_c   = 0;
    row_c   = 0;
    plane_c = 0;
    feature_q.delete();
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_K01, CFG_K23, CFG_K45, CFG_K67: kern_bank[int'(idx - CFG_K01)] = data;
      CFG_WIDTH:  width_reg  = data[WIDTH_W-1:0];
      CFG_HEIGHT: height_reg = data[HEIGHT_W-1:0];
      CFG_CHANS:  chan_reg   = data[CHAN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_window(pixel_t px, logic start);
    int unsigned      w, h, c, col;
    bit               last_win;
    logic [KERN_W-1:0] taps;
    int               acc;
    feat_rec_t        rec;
    w = clamp(width_reg, MIN_DIM, MAX_WIDTH);
    h = clamp(height_reg, MIN_DIM, MAX_HEIGHT);
    c = clamp(chan_reg, 1, MAX_CHANS);
    if (start) begin
      col_c   = 0;
      row_c   = 0;
      plane_c = 0;
    end
    col = (col_c >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_c;
    for (int r = 0; r < 3; r++) begin
      win[3*r]   = win[3*r+1];
      win[3*r+1] = win[3*r+2];
    end
    win[2] = rows_mem[1][col];
    win[5] = rows_mem[0][col];
    win[8] = px;
    rows_mem[1][col] = rows_mem[0][col];
    rows_mem[0][col] = px;

    if (col_c >= 2 && row_c >= 2) begin
      last_win = (col_c >= w - 1) && (row_c >= h - 1) && (plane_c >= c - 1);
      for (int k = 0; k < KERNELS; k++) begin
        taps = kern_bank[k/2][(k%2)*KERN_W +: KERN_W];
        acc  = 0;
        for (int t = 0; t < TAPS; t++) begin
          case (weight_code_t'(taps[2*t +: 2]))
            W_PLUS:  acc += win[t];
            W_MINUS: acc -= win[t];
            default: ;
          endcase
        end
        rec.feature = feat_t'(acc);
        rec.kidx    = KIDX_W'(k);
        rec.plane   = PLANE_W'(plane_c);
        rec.col     = COL_W'(col_c - 2);
        rec.row     = ROW_W'(row_c - 2);
        rec.last    = (k == KERNELS - 1);
        rec.eoi     = rec.last && last_win;
        feature_q.push_back(rec);
      end
    end

    if (col_c + 1 >= w) begin
      col_c = 0;
      if (row_c + 1 >= h) begin
        row_c = 0;
        plane_c = (plane_c + 1 >= c) ? 0 : plane_c + 1;
      end else begin
        row_c++;
      end
    end else begin
      col_c++;
    end
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("[%0t] %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_result();
    feat_rec_t want;
    if (feature_q.size() == 0) begin
      fail_count++;
      $display("[%0t] result with none outstanding: expected nothing, got feature %0d kernel %0d",
               $time, res_ch.feature, res_ch.kernel_index);
      return;
    end
    want = feature_q.pop_front();
    results_seen++;
    if (want.eoi) images_done++;
    check_field("feature", want.feature, res_ch.feature);
    check_field("kernel_index", {1'b0, want.kidx}, {1'b0, res_ch.kernel_index});
    check_field("plane", {1'b0, want.plane}, {1'b0, res_ch.plane});
    check_field("out_col", {1'b0, want.col}, {1'b0, res_ch.out_col});
    check_field("out_row", {1'b0, want.row}, {1'b0, res_ch.out_row});
    check_field("last_of_run", {1'b0, want.last}, {1'b0, res_ch.last_of_run});
    check_field("end_of_image", {1'b0, want.eoi}, {1'b0, res_ch.end_of_image});
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      fail_count   = 0;
      results_seen = 0;
      images_done  = 0;
    end else begin
      if (cfg_we) apply_cfg(cfg_index, cfg_data);
      if (px_ch.valid && px_ch.ready) predict_window(px_ch.pixel, px_ch.image_start);
      if (res_ch.valid && res_ch.ready) check_result();
    end
    pending = feature_q.size();
  end

endmodule

[sim/tb.sv]
// Top of the ternary 3x3 convolution testbench: clock, reset, register writes,
// pixel requests and result back-pressure. Depends on tcv_pkg, tcv_tb_pkg,
// tcv_ifs, tcv_feature_checker and the ternary_3x3_convolution RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcv_pkg::*;
  import tcv_tb_pkg::*;

  localparam int     SETTLE         = 8;
  localparam int     HOLD_CYCLES    = 120;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam pixel_t PIX_MAX        = {1'b0, {(PIXEL_W-1){1'b1}}};
  localparam pixel_t PIX_MIN        = {1'b1, {(PIXEL_W-1){1'b0}}};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count, pending, results_seen, images_done;
  int items_sent;
  int cfg_sets;
  int idle_cycles;
  bit quiet;
  bit hold_arm;
  bit hold_done;

  tcv_pix_if pix_ch ();
  tcv_res_if res_ch ();

  ternary_3x3_convolution dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (pix_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tcv_feature_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .px_ch        (pix_ch),
    .res_ch       (res_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .images_done  (images_done)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [KERN_W-1:0] uniform_kernel(weight_code_t code);
    return {TAPS{code}};
  endfunction

  function automatic logic [CFG_W-1:0] rand_word();
    return CFG_W'({$urandom, $urandom});
  endfunction

  function automatic pixel_t rand_px();
    case ($urandom_range(0, 9))
      0:       return PIX_MIN;
      1:       return PIX_MAX;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_random_kernels();
    for (int i = 0; i < KREGS; i++) write_reg(cfg_idx_t'(CFG_K01 + i), rand_word());
  endtask

  task automatic configure(logic [WIDTH_W-1:0] w, logic [HEIGHT_W-1:0] h,
                           logic [CHAN_W-1:0] c);
    write_reg(CFG_WIDTH, CFG_W'(w));
    write_reg(CFG_HEIGHT, CFG_W'(h));
    write_reg(CFG_CHANS, CFG_W'(c));
    cfg_we <= 1'b0;
    cfg_sets++;
  endtask

  task automatic send_px(pixel_t px, bit start);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= px;
    pix_ch.image_start <= start;
    do @(posedge clk); while (!pix_ch.ready);
    items_sent++;
  endtask

  // start_odds: one in N chance of a stray image start mid-stream, 0 for none
  task automatic feed_pixels(int n, bit start_first, int start_odds);
    for (int i = 0; i < n; i++)
      send_px(rand_px(), (i == 0 && start_first) ||
                         (start_odds > 0 && $urandom_range(1, start_odds) == 1));
  endtask

  task automatic drain();
    pix_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // result back-pressure: short random stalls, one long hold when armed
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_arm && !hold_done) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        res_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, pending);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_K01;
    cfg_data           <= '0;
    pix_ch.valid       <= 1'b0;
    pix_ch.pixel       <= '0;
    pix_ch.image_start <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extreme-value sums, every tap code, unused register index
    write_reg(CFG_K01, {uniform_kernel(W_MINUS), uniform_kernel(W_PLUS)});
    write_reg(CFG_K23, {uniform_kernel(W_ZERO), uniform_kernel(W_SPARE)});
    write_reg(CFG_K45, {KERN_W'(rand_word()),
                        {W_PLUS, W_MINUS, W_ZERO, W_SPARE, W_PLUS,
                         W_MINUS, W_MINUS, W_PLUS, W_ZERO}});
    write_reg(CFG_K67, rand_word());
    write_reg(CFG_UNUSED_IDX, '1);
    configure(3, 3, 2);
    for (int i = 0; i < 9; i++) send_px(PIX_MIN, i == 0);
    for (int i = 0; i < 9; i++) send_px(PIX_MAX, 1'b0);
    drain();

    load_random_kernels();
    configure(4, 4, 3);
    feed_pixels(48, 1'b1, 0);
    drain();

    // widest rows with clamped geometry; long result hold while rows keep coming
    load_random_kernels();
    configure('1, '0, '0);
    feed_pixels(130, 1'b1, 0);
    hold_arm = 1'b1;
    feed_pixels(62, 1'b0, 0);
    drain();

    load_random_kernels();
    configure('0, '1, '1);
    feed_pixels(30, 1'b1, 0);
    drain();

    begin
      int w, h, c;
      w = $urandom_range(3, 9);
      h = $urandom_range(3, 5);
      c = $urandom_range(1, 2);
      load_random_kernels();
      configure(WIDTH_W'(w), HEIGHT_W'(h), CHAN_W'(c));
      feed_pixels((2 * w * h * c > 90) ? 90 : 2 * w * h * c, 1'b1, 40);
      drain();
    end

    // geometry shrunk while counters sit past the new limits
    load_random_kernels();
    configure(12, 8, 1);
    feed_pixels(45, 1'b1, 0);
    drain();
    configure(5, 3, 1);
    feed_pixels(25, 1'b0, 0);
    drain();

    quiet = 1'b1;
    load_random_kernels();
    configure(6, 3, 2);
    feed_pixels(36, 1'b1, 0);
    drain();

    $display("Covered %0d pixel requests under %0d geometries, %0d feature results checked,",
             items_sent, cfg_sets, results_seen);
    $display("%0d images closed, %0d mismatches, %0d results outstanding.",
             images_done, fail_count, pending);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
